@@ rtl/core/msg_pkg.sv @@
// Shared types, opcode codes and share-pair tables for the masked share ALU.
// No dependencies; every other file in rtl/core refers to this package by scope.
package msg_pkg;

  parameter int DataW             = 64;
  parameter int HalfW             = DataW / 2;
  parameter int MaxShares         = 3;
  parameter int NumPairs          = MaxShares * (MaxShares - 1) / 2;
  parameter int DefaultShareCount = 3;
  parameter int OpW               = 3;
  parameter int ShareIdxW         = $clog2(MaxShares);

  typedef enum logic [OpW-1:0] {
    OP_XOR = 3'd0,
    OP_AND = 3'd1,
    OP_NOT = 3'd2,
    OP_ADD = 3'd3,
    OP_SUB = 3'd4,
    OP_MUL = 3'd5,
    OP_NEG = 3'd6
  } msg_op_t;

  typedef logic [ShareIdxW-1:0]             share_idx_t;
  typedef logic [MaxShares-1:0][DataW-1:0]  share_vec_t;
  typedef logic [NumPairs-1:0][DataW-1:0]   rand_vec_t;

  // Share pairs in random-word order: (0,1), (0,2), (1,2).
  parameter share_idx_t PairLo [NumPairs] = '{2'd0, 2'd0, 2'd1};
  parameter share_idx_t PairHi [NumPairs] = '{2'd1, 2'd2, 2'd2};

  // Stage load enables handed from the pipeline control to the multiplier.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } msg_adv_t;

  function automatic int clamp_shares(input int n);
    int c;
    c = n;
    if (c < 2) c = 2;
    if (c > MaxShares) c = MaxShares;
    return c;
  endfunction

endpackage

@@ rtl/core/msg_share_logic.sv @@
// Share-wise operations: xor, ISW and, not, add, sub, neg.
// Depends on msg_pkg; pure combinational logic fed from the input register.
module msg_share_logic #(
  parameter int SHARE_COUNT = msg_pkg::DefaultShareCount
) (
  input  msg_pkg::msg_op_t   op,
  input  msg_pkg::share_vec_t a,
  input  msg_pkg::share_vec_t b,
  input  msg_pkg::rand_vec_t  r,
  output msg_pkg::share_vec_t res
);

  localparam int NumSh = msg_pkg::clamp_shares(SHARE_COUNT);

  always_comb begin
    logic [msg_pkg::DataW-1:0] orig;
    logic [msg_pkg::DataW-1:0] inv;
    msg_pkg::share_vec_t       o;
    o    = '0;
    orig = '0;
    inv  = '0;
    unique case (op)
      msg_pkg::OP_XOR: begin
        for (int i = 0; i < NumSh; i++) o[i] = a[i] ^ b[i];
      end
      msg_pkg::OP_AND: begin
        for (int i = 0; i < NumSh; i++) o[i] = a[i] & b[i];
        for (int p = 0; p < msg_pkg::NumPairs; p++) begin
          if (int'(msg_pkg::PairHi[p]) < NumSh) begin
            o[msg_pkg::PairLo[p]] = o[msg_pkg::PairLo[p]] ^ r[p];
            o[msg_pkg::PairHi[p]] = o[msg_pkg::PairHi[p]] ^ r[p]
                ^ (a[msg_pkg::PairLo[p]] & b[msg_pkg::PairHi[p]])
                ^ (a[msg_pkg::PairHi[p]] & b[msg_pkg::PairLo[p]]);
          end
        end
      end
      msg_pkg::OP_NOT: begin
        for (int i = 0; i < NumSh; i++) begin
          o[i] = ~a[i];
          orig = orig ^ a[i];
          inv  = inv ^ ~a[i];
        end
        // fix share 0 so the recombined value is the complement
        o[0] = o[0] ^ inv ^ ~orig;
      end
      msg_pkg::OP_ADD: begin
        for (int i = 0; i < NumSh; i++) o[i] = a[i] + b[i];
      end
      msg_pkg::OP_SUB: begin
        for (int i = 0; i < NumSh; i++) o[i] = a[i] - b[i];
      end
      msg_pkg::OP_NEG: begin
        for (int i = 0; i < NumSh; i++) o[i] = '0 - a[i];
      end
      default: begin
        o = '0;
      end
    endcase
    res = o;
  end

endmodule

@@ rtl/core/msg_isw_mul.sv @@
// Pipelined ISW multiplication modulo 2^64 over the arithmetic shares.
// Depends on msg_pkg; stage enables come from the top-level pipeline control.
module msg_isw_mul #(
  parameter int SHARE_COUNT = msg_pkg::DefaultShareCount
) (
  input  logic                clk,
  input  msg_pkg::msg_adv_t   adv,
  input  msg_pkg::share_vec_t a,
  input  msg_pkg::share_vec_t b,
  input  msg_pkg::rand_vec_t  r,
  output msg_pkg::share_vec_t res
);

  localparam int NumSh = msg_pkg::clamp_shares(SHARE_COUNT);
  localparam int W     = msg_pkg::DataW;
  localparam int H     = msg_pkg::HalfW;
  localparam int S     = msg_pkg::MaxShares;
  localparam int P     = msg_pkg::NumPairs;

  logic [W-1:0]       ll   [S][S];
  logic [H-1:0]       lh   [S][S];
  logic [H-1:0]       hl   [S][S];
  logic [W-1:0]       prod [S][S];
  msg_pkg::rand_vec_t r1, r2, r3;
  msg_pkg::share_vec_t diag;
  msg_pkg::rand_vec_t  cross_sum;

  // stage 1: 32x32 partial products; only the low half of the cross terms counts
  always_ff @(posedge clk) begin
    if (adv.s1) begin
      for (int i = 0; i < S; i++) begin
        for (int j = 0; j < S; j++) begin
          if (i < NumSh && j < NumSh) begin
            ll[i][j] <= W'(a[i][H-1:0]) * W'(b[j][H-1:0]);
            lh[i][j] <= H'(a[i][H-1:0] * b[j][W-1:H]);
            hl[i][j] <= H'(a[i][W-1:H] * b[j][H-1:0]);
          end else begin
            ll[i][j] <= '0;
            lh[i][j] <= '0;
            hl[i][j] <= '0;
          end
        end
      end
      r1 <= r;
    end
  end

  // stage 2: fold partial products into full 64-bit products
  always_ff @(posedge clk) begin
    if (adv.s2) begin
      for (int i = 0; i < S; i++) begin
        for (int j = 0; j < S; j++) begin
          prod[i][j] <= {H'(ll[i][j][W-1:H] + lh[i][j] + hl[i][j]), ll[i][j][H-1:0]};
        end
      end
      r2 <= r1;
    end
  end

  // stage 3: diagonal terms and per-pair cross terms minus the pair's random word
  always_ff @(posedge clk) begin
    if (adv.s3) begin
      for (int i = 0; i < S; i++) diag[i] <= prod[i][i];
      for (int p = 0; p < P; p++) begin
        cross_sum[p] <= prod[msg_pkg::PairLo[p]][msg_pkg::PairHi[p]]
                      + prod[msg_pkg::PairHi[p]][msg_pkg::PairLo[p]] - r2[p];
      end
      r3 <= r2;
    end
  end

  always_comb begin
    msg_pkg::share_vec_t o;
    o = diag;
    for (int p = 0; p < P; p++) begin
      if (int'(msg_pkg::PairHi[p]) < NumSh) begin
        o[msg_pkg::PairLo[p]] = o[msg_pkg::PairLo[p]] + r3[p];
        o[msg_pkg::PairHi[p]] = o[msg_pkg::PairHi[p]] + cross_sum[p];
      end
    end
    res = o;
  end

endmodule

@@ rtl/core/masked_share_gadget_alu_unit.sv @@
// Top level of the masked share ALU: stream ports, pipeline control, result mux.
// Depends on msg_pkg, msg_share_logic and msg_isw_mul.
//
//  channel   dir  signals                       word contents
//  -------   ---  ----------------------------  -----------------------------------
//  s_        in   s_tvalid s_tready s_tdata/u   opcode, a shares, b shares, rands
//  m_        out  m_tvalid m_tready m_tdata     result shares 0..2
//
// One word is taken every cycle unless a stalled m_tready has filled every stage.
// The depth is set by the multiply path: 32x32 partial products, product fold,
// ISW cross terms, then the share sums into the output register.
// The five stages each hold one word and move on their own, so a stalled m_tready
// only backs up the pipe once every stage is full. rst clears the valid bits only.
module masked_share_gadget_alu_unit #(
  parameter int SHARE_COUNT = msg_pkg::DefaultShareCount
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // a_share_0, a_share_1, a_share_2, b_share_0, b_share_1, b_share_2,
  // rand_01, rand_02, rand_12 (64 bits each, lowest first)
  input  logic [9*msg_pkg::DataW-1:0]            s_tdata,
  // opcode
  input  logic [msg_pkg::OpW-1:0]                s_tuser,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // out_share_0, out_share_1, out_share_2 (64 bits each, lowest first)
  output logic [msg_pkg::MaxShares*msg_pkg::DataW-1:0] m_tdata
);

  localparam int W = msg_pkg::DataW;
  localparam int S = msg_pkg::MaxShares;
  localparam int P = msg_pkg::NumPairs;

  // stage valids: input register, three multiply stages, output register
  logic v0, v1, v2, v3, vout;
  logic go0, go1, go2, go3, go4;

  msg_pkg::msg_op_t    op0;
  msg_pkg::share_vec_t a0, b0, logic_res;
  msg_pkg::rand_vec_t  r0;
  msg_pkg::share_vec_t lr1, lr2, lr3, mul_res, out_q;
  logic                mul1, mul2, mul3;
  msg_pkg::msg_adv_t   adv;

  // A stage can take a new word when it is empty or its word moves on.
  assign go4      = !vout || m_tready;
  assign go3      = !v3 || go4;
  assign go2      = !v2 || go3;
  assign go1      = !v1 || go2;
  assign go0      = !v0 || go1;
  assign s_tready = go0;

  assign adv.s1 = go1 && v0;
  assign adv.s2 = go2 && v1;
  assign adv.s3 = go3 && v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0   <= 1'b0;
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      vout <= 1'b0;
    end else begin
      if (go0) v0 <= s_tvalid;
      if (go1) v1 <= v0;
      if (go2) v2 <= v1;
      if (go3) v3 <= v2;
      if (go4) vout <= v3;
    end
  end

  // input register: unpack the word
  always_ff @(posedge clk) begin
    if (go0 && s_tvalid) begin
      op0 <= msg_pkg::msg_op_t'(s_tuser);
      for (int i = 0; i < S; i++) begin
        a0[i] <= s_tdata[i*W +: W];
        b0[i] <= s_tdata[(S+i)*W +: W];
      end
      for (int p = 0; p < P; p++) r0[p] <= s_tdata[(2*S+p)*W +: W];
    end
  end

  msg_share_logic #(
    .SHARE_COUNT(SHARE_COUNT)
  ) u_logic (
    .op (op0),
    .a  (a0),
    .b  (b0),
    .r  (r0),
    .res(logic_res)
  );

  msg_isw_mul #(
    .SHARE_COUNT(SHARE_COUNT)
  ) u_mul (
    .clk(clk),
    .adv(adv),
    .a  (a0),
    .b  (b0),
    .r  (r0),
    .res(mul_res)
  );

  // carry the share-logic result alongside the multiply stages
  always_ff @(posedge clk) begin
    if (adv.s1) begin
      lr1  <= logic_res;
      mul1 <= (op0 == msg_pkg::OP_MUL);
    end
    if (adv.s2) begin
      lr2  <= lr1;
      mul2 <= mul1;
    end
    if (adv.s3) begin
      lr3  <= lr2;
      mul3 <= mul2;
    end
    if (go4 && v3) begin
      out_q <= mul3 ? mul_res : lr3;
    end
  end

  assign m_tvalid = vout;
  assign m_tdata  = out_q;

  // Input back-pressure only when every stage holds a word.
  assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (v0 && v1 && v2 && v3 && vout))
    else $error("input stalled while a pipeline stage is empty");

  // A word in the last multiply stage reaches the output when it has room.
  assert property (@(posedge clk) disable iff (rst)
    (v3 && go4) |=> m_tvalid)
    else $error("result lost between last stage and output register");

  // A taken result with nothing behind it leaves the output empty.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !v3) |=> !m_tvalid)
    else $error("result repeated on the output");

endmodule
